>>> rtl/priority_schedule_wait_times_defines.svh
// Assertion macros shared by the priority scheduler modules.
`ifndef PRIORITY_SCHEDULE_WAIT_TIMES_DEFINES_SVH
`define PRIORITY_SCHEDULE_WAIT_TIMES_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PSW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psw check failed: %m");
// next-cycle implication
`define PSW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psw check failed: %m");
`else
`define PSW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PSW_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/psw_pkg.sv
// Package: sizes, entry and handshake types for the priority scheduler.
`timescale 1ns / 1ps
package psw_pkg;

    localparam int MAX_PROCESSES = 16;
    localparam int IDX_W         = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CNT_W         = $clog2(MAX_PROCESSES + 1);

    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int ID_W    = 5;
    localparam int TAT_W   = 20;
    localparam int TOT_W   = 24;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PROCESSES);

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic               valid;
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
        logic               last;
        logic               dropped;
    } t_emit;

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_HEAD,
        S_SCAN,
        S_WB,
        S_ERD,
        S_EMIT
    } t_state;

endpackage

>>> rtl/psw_store.sv
// Job store: one synchronous memory of id, priority and burst per entry.
`timescale 1ns / 1ps
module psw_store
    import psw_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rdata
);

    t_entry r_mem [MAX_PROCESSES];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/psw_ctrl.sv
// Sequencer: batch load, exchange sort over the job store, schedule readout.
`timescale 1ns / 1ps
`include "priority_schedule_wait_times_defines.svh"
module psw_ctrl
    import psw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    input  logic [BURST_W-1:0] i_burst,
    input  logic [PRIO_W-1:0]  i_prio,
    input  logic               i_last,
    output logic               o_s_ready,
    output t_mem_req           o_mem,
    input  t_entry             i_rdata,
    output t_emit              o_emit,
    input  logic               i_take
);

    localparam int CW1 = CNT_W + 1;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_k, n_k;
    t_entry           r_cur, n_cur;

    logic             w_fire_in;
    logic             w_full;
    logic [CNT_W-1:0] w_load_cnt;
    logic [CNT_W:0]   w_id_full;
    logic             w_swap;
    logic             w_j_last;
    logic             w_i_done;
    logic             w_k_last;
    logic             w_fire_out;
    t_mem_req         w_mem;
    t_emit            w_emit;

    assign w_full     = (r_count >= MAX_CNT);
    assign w_fire_in  = i_s_valid && (r_state == S_LOAD);
    assign w_load_cnt = w_full ? r_count : r_count + 1'b1;
    assign w_id_full  = CW1'(r_count) + 1'b1;
    assign w_swap     = (r_cur.prio > i_rdata.prio);
    assign w_j_last   = ((CNT_W'(r_j) + 1'b1) == r_count);
    assign w_i_done   = ((CW1'(r_i) + CW1'(2)) >= CW1'(r_count));
    assign w_k_last   = ((CNT_W'(r_k) + 1'b1) == r_count);
    assign w_fire_out = (r_state == S_EMIT) && i_take;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (w_fire_in && i_last) begin
                    n_state = (w_load_cnt >= CNT_W'(2)) ? S_START : S_ERD;
                end
            end
            S_START: n_state = S_HEAD;
            S_HEAD:  n_state = S_SCAN;
            S_SCAN: begin
                if (w_j_last) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                n_state = w_i_done ? S_ERD : S_HEAD;
            end
            S_ERD:   n_state = S_EMIT;
            S_EMIT: begin
                if (w_fire_out && w_k_last) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // memory port, input ready, result request
    always_comb begin
        w_mem.we    = 1'b0;
        w_mem.waddr = r_j;
        w_mem.wdata = r_cur;
        w_mem.raddr = '0;
        o_s_ready   = 1'b0;
        w_emit.valid   = 1'b0;
        w_emit.id      = i_rdata.id;
        w_emit.burst   = i_rdata.burst;
        w_emit.last    = w_k_last;
        w_emit.dropped = r_ovf;
        case (r_state)
            S_LOAD: begin
                o_s_ready         = 1'b1;
                w_mem.we          = i_s_valid && !w_full;
                w_mem.waddr       = r_count[IDX_W-1:0];
                w_mem.wdata.id    = ID_W'(w_id_full);
                w_mem.wdata.prio  = i_prio;
                w_mem.wdata.burst = i_burst;
            end
            S_START: w_mem.raddr = '0;
            S_HEAD:  w_mem.raddr = r_i + 1'b1;
            S_SCAN: begin
                // push the held head down into slot j when j ranks ahead
                w_mem.we    = w_swap;
                w_mem.waddr = r_j;
                w_mem.raddr = r_j + 1'b1;
            end
            S_WB: begin
                w_mem.we    = 1'b1;
                w_mem.waddr = r_i;
                w_mem.raddr = r_i + 1'b1;
            end
            S_ERD:   w_mem.raddr = '0;
            S_EMIT: begin
                w_emit.valid = 1'b1;
                w_mem.raddr  = w_fire_out ? r_k + 1'b1 : r_k;
            end
            default: w_mem.raddr = '0;
        endcase
    end

    assign o_mem  = w_mem;
    assign o_emit = w_emit;

    // register next values
    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_cur   = r_cur;
        case (r_state)
            S_LOAD: begin
                if (w_fire_in) begin
                    n_count = w_load_cnt;
                    n_ovf   = r_ovf || w_full;
                    n_i     = '0;
                    n_k     = '0;
                end
            end
            S_HEAD: begin
                n_cur = i_rdata;
                n_j   = r_i + 1'b1;
            end
            S_SCAN: begin
                if (w_swap) begin
                    n_cur = i_rdata;
                end
                n_j = r_j + 1'b1;
            end
            S_WB:  n_i = r_i + 1'b1;
            S_ERD: n_k = '0;
            S_EMIT: begin
                if (w_fire_out) begin
                    n_k = r_k + 1'b1;
                    if (w_k_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: n_k = r_k;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
    end

    `PSW_ASSERT_IMP(a_no_rw_clash, i_clk, i_rst_n, w_mem.we && (r_state != S_LOAD), w_mem.waddr != w_mem.raddr)
    `PSW_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= MAX_CNT)
    `PSW_ASSERT_NXT(a_batch_clear, i_clk, i_rst_n, w_fire_out && w_k_last, (r_count == '0) && !r_ovf && (r_state == S_LOAD))

endmodule

>>> rtl/psw_out.sv
// Result stage: running sums and the registered output transaction.
`timescale 1ns / 1ps
`include "priority_schedule_wait_times_defines.svh"
module psw_out
    import psw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_emit            i_emit,
    output logic             o_take,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [ID_W-1:0]  o_id,
    output logic [TAT_W-1:0] o_tat,
    output logic [TAT_W-1:0] o_wt,
    output logic [TOT_W-1:0] o_tot_w,
    output logic [TOT_W-1:0] o_tot_t,
    output logic             o_dropped,
    output logic             o_last
);

    logic             r_valid, n_valid;
    logic [TAT_W-1:0] r_sum_bt, n_sum_bt;
    logic [TOT_W-1:0] r_tot_w, n_tot_w;
    logic [TOT_W-1:0] r_tot_t, n_tot_t;
    logic [ID_W-1:0]  r_id;
    logic [TAT_W-1:0] r_tat;
    logic [TAT_W-1:0] r_wt;
    logic [TOT_W-1:0] r_ow;
    logic [TOT_W-1:0] r_ot;
    logic             r_dropped;
    logic             r_last;

    logic             w_take;
    logic             w_fire;
    logic [TAT_W-1:0] w_tat;
    logic [TOT_W-1:0] w_tw;
    logic [TOT_W-1:0] w_tt;

    assign w_take = !r_valid || i_ready;
    assign w_fire = i_emit.valid && w_take;
    assign w_tat  = r_sum_bt + TAT_W'(i_emit.burst);
    assign w_tw   = r_tot_w + TOT_W'(r_sum_bt);
    assign w_tt   = r_tot_t + TOT_W'(w_tat);

    always_comb begin
        n_valid  = r_valid;
        n_sum_bt = r_sum_bt;
        n_tot_w  = r_tot_w;
        n_tot_t  = r_tot_t;
        if (w_fire) begin
            n_valid = 1'b1;
            if (i_emit.last) begin
                n_sum_bt = '0;
                n_tot_w  = '0;
                n_tot_t  = '0;
            end else begin
                n_sum_bt = w_tat;
                n_tot_w  = w_tw;
                n_tot_t  = w_tt;
            end
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_sum_bt <= '0;
            r_tot_w  <= '0;
            r_tot_t  <= '0;
        end else begin
            r_valid  <= n_valid;
            r_sum_bt <= n_sum_bt;
            r_tot_w  <= n_tot_w;
            r_tot_t  <= n_tot_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_id      <= i_emit.id;
            r_tat     <= w_tat;
            r_wt      <= r_sum_bt;
            r_ow      <= w_tw;
            r_ot      <= w_tt;
            r_dropped <= i_emit.dropped;
            r_last    <= i_emit.last;
        end
    end

    assign o_take    = w_take;
    assign o_valid   = r_valid;
    assign o_id      = r_id;
    assign o_tat     = r_tat;
    assign o_wt      = r_wt;
    assign o_tot_w   = r_ow;
    assign o_tot_t   = r_ot;
    assign o_dropped = r_dropped;
    assign o_last    = r_last;

    `PSW_ASSERT_NXT(a_sums_clear, i_clk, i_rst_n, w_fire && i_emit.last, (r_sum_bt == '0) && (r_tot_w == '0) && (r_tot_t == '0))
    `PSW_ASSERT_NXT(a_fire_loads, i_clk, i_rst_n, w_fire, r_valid)

endmodule

>>> rtl/priority_schedule_wait_times.sv
// Top level: nonpreemptive priority scheduler with wait and turnaround times.
`timescale 1ns / 1ps
//
// Input stream (s_axis): one job per transaction, burst time and priority in
// tdata, tlast marks the job that closes the batch. Jobs are numbered 1 up in
// arrival order. Jobs beyond MAX_PROCESSES are dropped and flagged on every
// result of that batch. tready is high only while the block loads a batch.
// Output stream (m_axis): one transaction per stored job, in schedule order
// (ascending priority, ties in exchange-sort order), tlast on the final one.
// Flow: loading accepts jobs back to back. The exchange sort runs in the job
// store with one read and at most one write per cycle, bounded by the single
// store port pair. Readout then gives one result per cycle while the receiver
// takes them, after the registered store read.
// Receiver stall: the output register holds its transaction and the readout
// waits; nothing is lost. The next batch is taken as soon as the last result
// sits in the output register.
// Reset (i_rst_n low, synchronous): empties the batch, clears the drop flag and
// the running sums. The job store needs no clearing pass.
module priority_schedule_wait_times
    import psw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] burst_time, [23:16] priority_level
    input  logic        s_axis_tlast,   // batch_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // [4:0] job_id, [24:5] turnaround, [44:25] waiting,
                                        // [68:45] total_waiting, [92:69] total_turnaround,
                                        // [95:93] zero
    output logic        m_axis_tuser,   // jobs_dropped
    output logic        m_axis_tlast    // run_last
);

    t_mem_req         w_mem;
    t_entry           w_rdata;
    t_emit            w_emit;
    logic             w_take;
    logic [ID_W-1:0]  w_id;
    logic [TAT_W-1:0] w_tat;
    logic [TAT_W-1:0] w_wt;
    logic [TOT_W-1:0] w_tot_w;
    logic [TOT_W-1:0] w_tot_t;

    // sequencer: load, sort in place, read out in schedule order
    psw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_burst   (s_axis_tdata[15:0]),
        .i_prio    (s_axis_tdata[23:16]),
        .i_last    (s_axis_tlast),
        .o_s_ready (s_axis_tready),
        .o_mem     (w_mem),
        .i_rdata   (w_rdata),
        .o_emit    (w_emit),
        .i_take    (w_take)
    );

    // job store, registered read
    psw_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_rdata (w_rdata)
    );

    // running sums and output register
    psw_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_emit    (w_emit),
        .o_take    (w_take),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_id      (w_id),
        .o_tat     (w_tat),
        .o_wt      (w_wt),
        .o_tot_w   (w_tot_w),
        .o_tot_t   (w_tot_t),
        .o_dropped (m_axis_tuser),
        .o_last    (m_axis_tlast)
    );

    // pack result fields, lowest field first, pad to whole bytes
    assign m_axis_tdata = {3'b000, w_tot_t, w_tot_w, w_wt, w_tat, w_id};

endmodule
